// ===== hw/rtl/bfk_pkg.sv =====
`timescale 1ns / 1ps
package bfk_pkg;

	localparam int COMP_W     = 16;
	localparam int SQ_W       = 32;
	localparam int DIST_W     = 40;
	localparam int IDX_W      = 32;
	localparam int DIMS_CFG_W = 9;
	localparam int K_CFG_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int CMD_W      = 2;
	localparam int OUT_DATA_W = IDX_W + DIST_W;

	// command codes carried on s_tuser
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_K    = 1'b1;

	// front end to distance unit, one stage after accept
	typedef struct packed {
		logic                     data;
		logic                     fin;
		logic                     eov;
		logic signed [COMP_W-1:0] comp;
		logic signed [COMP_W-1:0] qval;
		logic [IDX_W-1:0]         idx;
	} fe_item_t;

	// distance unit to neighbor list
	typedef struct packed {
		logic              cand;
		logic              fin;
		logic [DIST_W-1:0] sqdist;
		logic [IDX_W-1:0]  idx;
	} cand_t;

endpackage

// ===== hw/rtl/bfk_front.sv =====
`timescale 1ns / 1ps
module bfk_front
	import bfk_pkg::*;
#(
	parameter int MAX_DIMS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [COMP_W-1:0]     s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic [DIMS_CFG_W-1:0] dims_cfg,
	input  logic                  emit_done,
	output fe_item_t              item
);

	localparam int DAW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DCW = $clog2(MAX_DIMS + 1);
	localparam int EW  = (DCW > DIMS_CFG_W) ? DCW : DIMS_CFG_W;

	logic [COMP_W-1:0] query_mem [MAX_DIMS];

	logic              busy_q;
	logic [DAW-1:0]    fill_q;
	logic [DAW-1:0]    cnt_q;
	logic [IDX_W-1:0]  vcnt_q;
	logic              data_s1;
	logic              fin_s1;
	logic              eov_s1;
	logic [COMP_W-1:0] comp_s1;
	logic [COMP_W-1:0] qval_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic          accept;
	logic [EW-1:0] dims_ext;
	logic [EW-1:0] eff_dims;
	logic [EW-1:0] fill_inc;
	logic [EW-1:0] cnt_inc;
	logic          eov;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !busy_q;

	assign dims_ext = EW'(dims_cfg);
	assign eff_dims = (dims_ext == '0) ? EW'(1) :
	                  (dims_ext > EW'(MAX_DIMS)) ? EW'(MAX_DIMS) : dims_ext;
	assign fill_inc = EW'(fill_q) + EW'(1);
	assign cnt_inc  = EW'(cnt_q) + EW'(1);
	assign eov      = (cnt_inc >= eff_dims);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fill_q  <= '0;
			cnt_q   <= '0;
			vcnt_q  <= '0;
			data_s1 <= 1'b0;
			fin_s1  <= 1'b0;
			eov_s1  <= 1'b0;
		end else begin
			data_s1 <= accept && (s_tuser == CMD_DATA);
			fin_s1  <= accept && (s_tuser == CMD_FINISH);
			eov_s1  <= accept && (s_tuser == CMD_DATA) && eov;
			if (emit_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (s_tuser)
					CMD_QUERY: begin
						fill_q <= (fill_inc >= eff_dims) ? '0 : fill_inc[DAW-1:0];
					end
					CMD_DATA: begin
						if (eov) begin
							cnt_q <= '0;
							if (vcnt_q != '1) begin
								vcnt_q <= vcnt_q + IDX_W'(1);
							end
						end else begin
							cnt_q <= cnt_inc[DAW-1:0];
						end
					end
					CMD_FINISH: begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
						vcnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == CMD_QUERY)) begin
			query_mem[fill_q] <= s_tdata;
		end
		qval_s1 <= query_mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		comp_s1 <= s_tdata;
		idx_s1  <= vcnt_q;
	end

	assign item.data = data_s1;
	assign item.fin  = fin_s1;
	assign item.eov  = eov_s1;
	assign item.comp = comp_s1;
	assign item.qval = qval_s1;
	assign item.idx  = idx_s1;

endmodule

// ===== hw/rtl/bfk_dist.sv =====
`timescale 1ns / 1ps
module bfk_dist
	import bfk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  fe_item_t item,
	output cand_t    cand
);

	logic              data_s2;
	logic              fin_s2;
	logic              eov_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [DIST_W-1:0] acc_q;
	logic              cand_s3;
	logic              fin_s3;
	logic [DIST_W-1:0] dist_s3;
	logic [IDX_W-1:0]  idx_s3;

	logic signed [COMP_W:0] diff;
	logic [COMP_W-1:0]      mag;
	logic [DIST_W:0]        sum;
	logic [DIST_W-1:0]      sum_sat;

	// difference magnitude never exceeds 16 bits
	assign diff = {item.comp[COMP_W-1], item.comp} - {item.qval[COMP_W-1], item.qval};
	assign mag  = diff[COMP_W] ? COMP_W'(-diff) : COMP_W'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_s2 <= 1'b0;
			fin_s2  <= 1'b0;
			eov_s2  <= 1'b0;
		end else begin
			data_s2 <= item.data;
			fin_s2  <= item.fin;
			eov_s2  <= item.eov;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2  <= mag * mag;
		idx_s2 <= item.idx;
	end

	assign sum     = {1'b0, acc_q} + (DIST_W+1)'(sq_s2);
	assign sum_sat = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cand_s3 <= 1'b0;
			fin_s3  <= 1'b0;
		end else begin
			cand_s3 <= data_s2 && eov_s2;
			fin_s3  <= fin_s2;
			if (fin_s2 || (data_s2 && eov_s2)) begin
				acc_q <= '0;
			end else if (data_s2) begin
				acc_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= sum_sat;
		idx_s3  <= idx_s2;
	end

	assign cand.cand   = cand_s3;
	assign cand.fin    = fin_s3;
	assign cand.sqdist = dist_s3;
	assign cand.idx    = idx_s3;

endmodule

// ===== hw/rtl/bfk_list.sv =====
`timescale 1ns / 1ps
module bfk_list
	import bfk_pkg::*;
#(
	parameter int MAX_K = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cand_t                 cand,
	input  logic [K_CFG_W-1:0]    k_cfg,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]            m_tuser,
	output logic                  m_tlast,
	output logic                  emit_done
);

	localparam int CW  = $clog2(MAX_K + 1);
	localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int KEW = (CW > K_CFG_W) ? CW : K_CFG_W;

	logic [DIST_W-1:0] dist_q [MAX_K];
	logic [IDX_W-1:0]  idx_q  [MAX_K];
	logic [CW-1:0]     count_q;
	logic              emit_q;
	logic [KIW-1:0]    ptr_q;
	logic [CW-1:0]     n_q;
	logic              out_vld_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_found_q;
	logic              out_last_q;

	logic [KEW-1:0]    k_ext;
	logic [CW-1:0]     eff_k;
	logic [CW-1:0]     n_trim;
	logic              full;
	logic [KIW-1:0]    worst_ptr;
	logic              take;
	logic [CW-1:0]     n_ins;
	logic [MAX_K-1:0]  ge;
	logic [MAX_K-1:0]  sh;
	logic              load;
	logic              last_now;

	assign k_ext     = KEW'(k_cfg);
	assign eff_k     = (k_ext == '0) ? CW'(1) :
	                   (k_ext > KEW'(MAX_K)) ? CW'(MAX_K) : k_ext[CW-1:0];
	assign n_trim    = (count_q > eff_k) ? eff_k : count_q;
	assign full      = (n_trim >= eff_k);
	assign worst_ptr = KIW'(eff_k - CW'(1));
	assign take      = cand.cand && (!full || (cand.sqdist < dist_q[worst_ptr]));
	assign n_ins     = full ? (eff_k - CW'(1)) : n_trim;

	// entries that move down one place; sorted order makes ge a run of ones
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			ge[i] = (CW'(i) < n_ins) && (dist_q[i] > cand.sqdist);
		end
		sh = ge << 1;
	end

	for (genvar g = 0; g < MAX_K; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (take) begin
				if (sh[g]) begin
					if (g > 0) begin
						dist_q[g] <= dist_q[(g > 0) ? g - 1 : 0];
						idx_q[g]  <= idx_q[(g > 0) ? g - 1 : 0];
					end
				end else if (ge[g] || (n_ins == CW'(g))) begin
					dist_q[g] <= cand.sqdist;
					idx_q[g]  <= cand.idx;
				end
			end
		end
	end

	assign load      = emit_q && (!out_vld_q || m_tready);
	assign last_now  = (n_q == '0) || ((CW'(ptr_q) + CW'(1)) == n_q);
	assign emit_done = load && last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			emit_q    <= 1'b0;
			ptr_q     <= '0;
			n_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// a rejected candidate still trims a list left over from a larger k
			if (cand.cand) begin
				count_q <= take ? (n_ins + CW'(1)) : n_trim;
			end
			if (cand.fin) begin
				emit_q  <= 1'b1;
				ptr_q   <= '0;
				n_q     <= n_trim;
				count_q <= '0;
			end else if (load) begin
				ptr_q <= ptr_q + KIW'(1);
				if (last_now) begin
					emit_q <= 1'b0;
				end
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_last_q <= last_now;
			if (n_q == '0) begin
				out_idx_q   <= '0;
				out_dist_q  <= '0;
				out_found_q <= 1'b0;
			end else begin
				out_idx_q   <= idx_q[ptr_q];
				out_dist_q  <= dist_q[ptr_q];
				out_found_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_dist_q, out_idx_q};
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/brute_force_knn_top_k.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   tdata: component; tuser: command
// m_       out  m_tvalid/m_tready   tdata: neighbor_index, neighbor_distance;
//                                   tuser: found; tlast: last
// cfg_     in   cfg_we              cfg_index selects register, cfg_data value
//
// Query, dataset and unknown requests: one per cycle while s_tready is high;
// a completed vector passes three register stages before it enters the list.
// Finish: s_tready drops until the last of max(n, 1) results, n = kept neighbors,
// is loaded, after the three register stages to the list and one result per
// cycle into the output register; stalls on m_tready stretch the run.
// Reset: control clears at once; the query memory holds garbage until loaded.
module brute_force_knn_top_k
	import bfk_pkg::*;
#(
	parameter int MAX_DIMS = 256,
	parameter int MAX_K    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [COMP_W-1:0]     s_tdata,   // [15:0] component
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] neighbor_index, [71:32] neighbor_distance
	output logic [0:0]            m_tuser,   // [0] found
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DIMS_CFG_W-1:0] dims_q;
	logic [K_CFG_W-1:0]    k_q;
	fe_item_t              item;
	cand_t                 cand;
	logic                  emit_done;

	// Configuration registers; the user writes them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_CFG_W'(128);
			k_q    <= K_CFG_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS: dims_q <= cfg_data[DIMS_CFG_W-1:0];
				REG_K:    k_q    <= cfg_data[K_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Accept requests, track query fill, component and vector counters,
	// read the stored query component for the incoming dataset component.
	// Hold s_tready low from a finish until its last result is loaded.
	bfk_front #(
		.MAX_DIMS (MAX_DIMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.dims_cfg  (dims_q),
		.emit_done (emit_done),
		.item      (item)
	);

	// Square the component difference, then accumulate with saturation;
	// drop a partial vector when a finish passes.
	bfk_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cand   (cand)
	);

	// Insert completed vectors into the sorted list, all entries shifting in parallel, and
	// stream the list out through the output register on finish.
	bfk_list #(
		.MAX_K (MAX_K)
	) u_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand),
		.k_cfg     (k_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.emit_done (emit_done)
	);

endmodule

// ===== hw/rtl/bfk_checker.sv =====
`timescale 1ns / 1ps
module bfk_checker
	import bfk_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [CMD_W-1:0]      s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]            m_tuser,
	input logic                  m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a not-found result stands alone and carries zeros
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("not-found result malformed");

	// input stalls only after a finish request
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && (s_tuser == CMD_FINISH)))
		else $error("input stalled without finish");

	// results start only while a finish run holds the input
	a_out_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without finish run");

endmodule

bind brute_force_knn_top_k bfk_checker u_bfk_checker (.*);

// ===== tb/knn_checker.sv =====
`timescale 1ns / 1ps
module knn_checker
	import bfk_pkg::*;
#(
	parameter int MAX_DIMS = 256,
	parameter int MAX_K    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [COMP_W-1:0]     s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [0:0]            m_tuser,
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    results_seen
);

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sqdist;
		logic              found;
		logic              last;
	} neighbor_t;

	localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;
	localparam logic [IDX_W-1:0] IDX_SAT = {IDX_W{1'b1}};

	logic [DIMS_CFG_W-1:0] dims_reg;
	logic [K_CFG_W-1:0]    k_reg;
	logic [COMP_W-1:0]     query_mem [MAX_DIMS];
	int unsigned           query_pos;
	int unsigned           comp_pos;
	logic [DIST_W-1:0]     dist_acc;
	logic [IDX_W-1:0]      vec_no;
	logic [DIST_W-1:0]     kept_dist [MAX_K];
	logic [IDX_W-1:0]      kept_idx [MAX_K];
	int unsigned           kept_n;
	neighbor_t             neighbors_due [$];

	function automatic int unsigned dims_eff();
		if (dims_reg == 0) return 1;
		if (dims_reg > MAX_DIMS) return MAX_DIMS;
		return dims_reg;
	endfunction

	function automatic int unsigned k_eff();
		if (k_reg == 0) return 1;
		if (k_reg > MAX_K) return MAX_K;
		return k_reg;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < 40)
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// sorted insert; an equal distance never displaces a kept entry
	task automatic keep_nearest(input logic [DIST_W-1:0] cand_dist,
			input logic [IDX_W-1:0] idx);
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		if (kept_n > k_eff()) kept_n = k_eff();
		n = kept_n;
		if (n >= k_eff()) begin
			if (cand_dist >= kept_dist[k_eff() - 1]) return;
			n = k_eff() - 1;
		end
		pos = n;
		while (pos > 0 && kept_dist[pos - 1] > cand_dist) pos--;
		for (i = n; i > pos; i--) begin
			kept_dist[i] = kept_dist[i - 1];
			kept_idx[i]  = kept_idx[i - 1];
		end
		kept_dist[pos] = cand_dist;
		kept_idx[pos]  = idx;
		kept_n = n + 1;
	endtask

	task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [COMP_W-1:0] comp);
		logic [COMP_W-1:0] qv;
		int                diff;
		longint unsigned   mag;
		longint unsigned   sum;
		neighbor_t         nb;
		int unsigned       i;
		case (cmd)
		CMD_QUERY: begin
			if (query_pos < MAX_DIMS) query_mem[query_pos] = comp;
			query_pos++;
			if (query_pos >= dims_eff()) query_pos = 0;
		end
		CMD_DATA: begin
			qv = (comp_pos < MAX_DIMS) ? query_mem[comp_pos] : '0;
			diff = $signed(comp) - $signed(qv);
			mag = (diff < 0) ? -diff : diff;
			sum = dist_acc + mag * mag;
			if (sum > DIST_SAT) sum = DIST_SAT;
			dist_acc = sum[DIST_W-1:0];
			comp_pos++;
			if (comp_pos >= dims_eff()) begin
				keep_nearest(dist_acc, vec_no);
				if (vec_no != IDX_SAT) vec_no++;
				comp_pos = 0;
				dist_acc = '0;
			end
		end
		CMD_FINISH: begin
			if (kept_n > k_eff()) kept_n = k_eff();
			if (kept_n == 0) begin
				nb.idx    = '0;
				nb.sqdist = '0;
				nb.found  = 1'b0;
				nb.last   = 1'b1;
				neighbors_due.insert(neighbors_due.size(), nb);
			end else begin
				for (i = 0; i < kept_n; i++) begin
					nb.idx    = kept_idx[i];
					nb.sqdist = kept_dist[i];
					nb.found  = 1'b1;
					nb.last   = (i + 1 == kept_n);
					neighbors_due.insert(neighbors_due.size(), nb);
				end
			end
			kept_n   = 0;
			vec_no   = '0;
			comp_pos = 0;
			dist_acc = '0;
		end
		default: ;
		endcase
	endtask

	task automatic check_result();
		neighbor_t want;
		results_seen++;
		if (neighbors_due.size() == 0) begin
			report_mismatch("result with nothing outstanding, index",
				64'(m_tdata[IDX_W-1:0]), '0);
			return;
		end
		want = neighbors_due.pop_front();
		if (m_tdata[IDX_W-1:0] != want.idx)
			report_mismatch("neighbor index", 64'(m_tdata[IDX_W-1:0]), 64'(want.idx));
		if (m_tdata[OUT_DATA_W-1:IDX_W] != want.sqdist)
			report_mismatch("neighbor distance", 64'(m_tdata[OUT_DATA_W-1:IDX_W]),
				64'(want.sqdist));
		if (m_tuser[0] != want.found)
			report_mismatch("found flag", 64'(m_tuser[0]), 64'(want.found));
		if (m_tlast != want.last)
			report_mismatch("last flag", 64'(m_tlast), 64'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_reg  = 9'd128;
			k_reg     = 5'd10;
			query_pos = 0;
			comp_pos  = 0;
			dist_acc  = '0;
			vec_no    = '0;
			kept_n    = 0;
			neighbors_due.delete();
			pending   = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DIMS) dims_reg = cfg_data[DIMS_CFG_W-1:0];
				else if (cfg_index == REG_K) k_reg = cfg_data[K_CFG_W-1:0];
			end
			if (m_tvalid && m_tready) check_result();
			if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
			pending = neighbors_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import bfk_pkg::*;

	localparam int MAX_DIMS     = 256;
	localparam int MAX_K        = 16;
	localparam int CYCLE_LIMIT  = 300000;
	// finish path runs through the distance pipeline, then up to MAX_K results; give it some slack
	localparam int DRAIN_CYCLES = 40;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [COMP_W-1:0]     s_tdata = '0;    // [15:0] component
	logic [CMD_W-1:0]      s_tuser = CMD_QUERY;  // [1:0] command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;   // [31:0] neighbor_index, [71:32] neighbor_distance
	logic [0:0]            m_tuser;   // [0] found
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_DIMS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int results_seen;
	int cycle_count;
	int src_idle_pct;
	int sink_stall_pct;
	int requests_sent;
	int settings_used;

	// Sender-side view of the block: where the next query and data components
	// land, and which query entries hold a value. Keeps data requests away from
	// query entries that were never loaded.
	int unsigned dims_now = 128;
	int unsigned fill_now;
	int unsigned pos_now;
	bit          query_loaded [MAX_DIMS];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Receiver: decide readiness for the next edge on every falling edge.
	always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

	brute_force_knn_top_k #(
		.MAX_DIMS(MAX_DIMS),
		.MAX_K   (MAX_K)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	knn_checker #(
		.MAX_DIMS(MAX_DIMS),
		.MAX_K   (MAX_K)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen)
	);

	// Half small values so equal distances (ties) show up often, the rest
	// full-range words and the two extremes.
	function automatic logic [COMP_W-1:0] rand_comp();
		case ($urandom_range(3))
		0, 1: return COMP_W'($urandom_range(4)) - COMP_W'(2);
		2: return COMP_W'($urandom);
		default: return $urandom_range(1) ? {1'b1, {(COMP_W-1){1'b0}}}
			: {1'b0, {(COMP_W-1){1'b1}}};
		endcase
	endfunction

	function automatic bit query_complete();
		for (int unsigned i = 0; i < dims_now; i++)
			if (!query_loaded[i]) return 1'b0;
		return 1'b1;
	endfunction

	task automatic set_flow(input flow_t flow);
		case (flow)
		FLOW_FREE: begin
			src_idle_pct   = 0;
			sink_stall_pct = 0;
		end
		FLOW_SRC_IDLE: begin
			src_idle_pct   = 82;
			sink_stall_pct = 0;
		end
		FLOW_SINK_STALL: begin
			src_idle_pct   = 0;
			sink_stall_pct = 82;
		end
		default: begin
			src_idle_pct   = 13;
			sink_stall_pct = 13;
		end
		endcase
	endtask

	// Present one request, hold it until the block takes it, then advance the
	// sender-side view. tvalid stays high after the accept so back-to-back
	// requests need no second assignment in the same step.
	task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [COMP_W-1:0] comp);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= comp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
		case (cmd)
		CMD_QUERY: begin
			if (fill_now < MAX_DIMS) query_loaded[fill_now] = 1'b1;
			fill_now++;
			if (fill_now >= dims_now) fill_now = 0;
		end
		CMD_DATA: begin
			pos_now++;
			if (pos_now >= dims_now) pos_now = 0;
		end
		CMD_FINISH: pos_now = 0;
		default: ;
		endcase
	endtask

	// Drop tvalid, wait for every outstanding neighbor, then let the list
	// pipeline settle before any register write.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIMS) begin
			if (val[DIMS_CFG_W-1:0] == 0) dims_now = 1;
			else if (val[DIMS_CFG_W-1:0] > MAX_DIMS) dims_now = MAX_DIMS;
			else dims_now = val[DIMS_CFG_W-1:0];
		end
	endtask

	// One register setting: load a full query, stream mostly dataset
	// components with the odd query reload, unused command and finish, then
	// close either with a finish or by completing the open vector. Closing
	// without a finish leaves the neighbor list filled so the next setting
	// can shrink or grow k against it.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] dims_raw,
			input logic [CFG_DATA_W-1:0] k_raw, input flow_t flow, input int n_items,
			input bit close_by_finish);
		int unsigned pick;
		write_reg(REG_DIMS, dims_raw);
		write_reg(REG_K, k_raw);
		set_flow(flow);
		settings_used++;
		while (!query_complete()) send_req(CMD_QUERY, rand_comp());
		repeat (n_items) begin
			pick = $urandom_range(99);
			if ($urandom_range(4 * dims_now + 3) == 0)
				send_req(CMD_FINISH, rand_comp());
			else if (pick < 3)
				send_req(CMD_UNUSED, rand_comp());
			else if (pick < 8 || !query_loaded[pos_now])
				send_req(CMD_QUERY, rand_comp());
			else
				send_req(CMD_DATA, rand_comp());
		end
		if (close_by_finish)
			send_req(CMD_FINISH, rand_comp());
		else
			while (pos_now != 0) send_req(CMD_DATA, rand_comp());
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: two-component vectors, keep three.
		write_reg(REG_DIMS, 9'd2);
		write_reg(REG_K, 9'd3);
		set_flow(FLOW_FREE);
		settings_used++;
		// finish with nothing seen: one not-found result
		send_req(CMD_FINISH, '0);
		// query at both extremes
		send_req(CMD_QUERY, 16'h8000);
		send_req(CMD_QUERY, 16'h7fff);
		// largest possible distance, then an exact match
		send_req(CMD_DATA, 16'h7fff);
		send_req(CMD_DATA, 16'h8000);
		send_req(CMD_DATA, 16'h8000);
		send_req(CMD_DATA, 16'h7fff);
		send_req(CMD_UNUSED, 16'hffff);
		// three equal distances: second displaces the worst, third loses the tie
		repeat (3) begin
			send_req(CMD_DATA, '0);
			send_req(CMD_DATA, '0);
		end
		// half a vector, thrown away by the finish
		send_req(CMD_DATA, 16'h0005);
		send_req(CMD_FINISH, 16'hffff);
		send_req(CMD_FINISH, '0);
		drain();

		// Random: settings cover the register extremes (zero, max, above max)
		// and upper cfg_data bits that the k register drops.
		run_phase(9'd1,   9'd1,   FLOW_FREE,       15, 1'b1);
		run_phase(9'd5,   9'd16,  FLOW_SRC_IDLE,   25, 1'b0);
		run_phase(9'd3,   9'd4,   FLOW_SINK_STALL, 25, 1'b1);
		run_phase(9'd0,   9'd0,   FLOW_BOTH,       15, 1'b0);
		run_phase(9'd8,   9'd31,  FLOW_FREE,       20, 1'b0);
		run_phase(9'd2,   9'h1e5, FLOW_SRC_IDLE,   20, 1'b1);
		run_phase(9'd511, 9'd16,  FLOW_SINK_STALL, 10, 1'b1);
		run_phase(9'd4,   9'd10,  FLOW_BOTH,       20, 1'b1);

		$display("covered %0d requests over %0d register settings and four flow mixes",
			requests_sent, settings_used);
		$display("checked %0d neighbor results", results_seen);
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== brute_force_knn_top_k.f =====
hw/rtl/bfk_pkg.sv
hw/rtl/bfk_front.sv
hw/rtl/bfk_dist.sv
hw/rtl/bfk_list.sv
hw/rtl/brute_force_knn_top_k.sv
hw/rtl/bfk_checker.sv
tb/knn_checker.sv
tb/tb.sv
